@@ hw/rtl/srr_pkg.sv @@
// ----------------------------------------------------------------------------
// srr_pkg - selective repeat receiver shared types
// payload structs, parser event and report codes
// ----------------------------------------------------------------------------
package srr_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] report_kind;
      logic [7:0] frame_seq;
      logic [7:0] frame_len;
      logic       last_report;
   } rsp_payload_type;

   // checksum byte seen, with the verdict and the frame header
   typedef struct packed {
      logic       done;
      logic       sum_ok;
      logic [7:0] seq;
      logic [7:0] len;
   } frame_event_type;

   localparam logic [1:0] KIND_ACK       = 2'd0;
   localparam logic [1:0] KIND_DELIVERED = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM   = 2'd2;
   localparam logic [1:0] KIND_RANGE     = 2'd3;

   localparam logic [7:0] SUM_MASK = 8'hFF;

endpackage

@@ hw/rtl/srr_chan_if.sv @@
// ----------------------------------------------------------------------------
// srr_chan_if - valid/ready channel
// one transfer per clock edge with valid and ready both high
// ----------------------------------------------------------------------------
interface srr_chan_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/srr_ram.sv @@
// ----------------------------------------------------------------------------
// srr_ram - generic single write, single read ram
// registered read data, held while rd_en is low
// ----------------------------------------------------------------------------
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/srr_parse.sv @@
// ----------------------------------------------------------------------------
// srr_parse - frame byte parser
// tracks byte position and additive checksum, flags the checksum byte
// ----------------------------------------------------------------------------
module srr_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     frame_start,
   output srr_pkg::frame_event_type evt
);
   logic [8:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] len_ff, len_in;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      seq_in = seq_ff;
      len_in = len_ff;
      evt    = '0;
      if (accept) begin
         priority if (frame_start) begin
            seq_in = data_byte;
            sum_in = data_byte;
            pos_in = 9'd1;
         end else if (pos_ff == 9'd0) begin
            // stray byte while idle
            pos_in = pos_ff;
         end else if (pos_ff == 9'd1) begin
            len_in = data_byte;
            sum_in = (sum_ff + data_byte) & srr_pkg::SUM_MASK;
            pos_in = 9'd2;
         end else if (pos_ff < ({1'b0, len_ff} + 9'd2)) begin
            sum_in = (sum_ff + data_byte) & srr_pkg::SUM_MASK;
            pos_in = pos_ff + 9'd1;
         end else begin
            // checksum byte
            pos_in     = 9'd0;
            evt.done   = 1'b1;
            evt.sum_ok = (data_byte == sum_ff);
            evt.seq    = seq_ff;
            evt.len    = len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         seq_ff <= '0;
         len_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         seq_ff <= seq_in;
         len_ff <= len_in;
      end
   end
endmodule

@@ hw/rtl/selective_repeat_receiver_top.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top - selective repeat arq receiver
// report: a frame's report (ack or discard) is shown in the cycle after its checksum byte
// each in-order delivery then takes a slot length ram read, then an output load that waits for a free output
// throughput: 1 byte per cycle while idle and the output is free; a walk of deliveries holds off input
// reset: parser, expected slot and all received marks clear at once, no clearing pass
// slot length ram keeps its contents; it is read only for marked slots
// ----------------------------------------------------------------------------
module selective_repeat_receiver_top #(
   parameter int SLOTS = 8
) (
   input logic        clock,
   input logic        reset,
   srr_chan_if.sink   req_chan,
   srr_chan_if.source rsp_chan
);
   localparam int SW = $clog2(SLOTS);

   // walk sequencer codes
   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_WALK_RD  = 2'd1;
   localparam logic [1:0] ST_WALK_OUT = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [SLOTS-1:0]         rcvd_ff, rcvd_in;
   logic [SW-1:0]            exp_ff, exp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   srr_pkg::rsp_payload_type rsp_ff, rsp_in;

   srr_pkg::frame_event_type evt;
   logic                     out_free;
   logic                     req_ready;
   logic                     accept;
   logic                     in_range;
   logic [SW-1:0]            seq_idx;
   logic [SW-1:0]            exp_next;
   logic [SLOTS-1:0]         set_mask;
   logic [SLOTS-1:0]         clr_mask;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [7:0]               ram_rd_data;

   // output register frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_chan.valid && req_ready;

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   srr_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_chan.payload.data_byte),
      .frame_start (req_chan.payload.frame_start),
      .evt         (evt)
   );

   assign in_range = evt.seq < 8'(SLOTS);
   assign seq_idx  = evt.seq[SW-1:0];
   assign set_mask = SLOTS'(1) << seq_idx;
   assign clr_mask = SLOTS'(1) << exp_ff;
   // expected slot wraps modulo the slot count
   assign exp_next = (exp_ff == SW'(SLOTS - 1)) ? '0 : exp_ff + 1'b1;

   // slot lengths: written on a good in-range frame, read one slot per walk step
   srr_ram #(
      .WIDTH (8),
      .DEPTH (SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (seq_idx),
      .wr_data (evt.len),
      .rd_en   (ram_rd_en),
      .rd_addr (exp_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      rcvd_in      = rcvd_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // checksum byte: one discard report or an ack, maybe a walk after it
            if (evt.done) begin
               rsp_valid_in     = 1'b1;
               rsp_in.frame_seq = evt.seq;
               rsp_in.frame_len = evt.len;
               priority if (!evt.sum_ok) begin
                  rsp_in.report_kind = srr_pkg::KIND_BAD_SUM;
                  rsp_in.last_report = 1'b1;
               end else if (!in_range) begin
                  rsp_in.report_kind = srr_pkg::KIND_RANGE;
                  rsp_in.last_report = 1'b1;
               end else begin
                  ram_wr_en          = 1'b1;
                  rcvd_in            = rcvd_ff | set_mask;
                  rsp_in.report_kind = srr_pkg::KIND_ACK;
                  rsp_in.last_report = !rcvd_in[exp_ff];
                  if (rcvd_in[exp_ff]) begin
                     state_in = ST_WALK_RD;
                  end
               end
            end
         end
         ST_WALK_RD: begin
            // length writes of all marked slots have landed, safe to read
            ram_rd_en = 1'b1;
            state_in  = ST_WALK_OUT;
         end
         ST_WALK_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.report_kind = srr_pkg::KIND_DELIVERED;
               rsp_in.frame_seq   = 8'(exp_ff);
               rsp_in.frame_len   = ram_rd_data;
               rcvd_in            = rcvd_ff & ~clr_mask;
               exp_in             = exp_next;
               rsp_in.last_report = !rcvd_in[exp_next];
               state_in           = rcvd_in[exp_next] ? ST_WALK_RD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rcvd_ff      <= '0;
         exp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rcvd_ff      <= rcvd_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // report payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // walk only ever delivers a marked slot
   a_walk_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_OUT) |-> rcvd_ff[exp_ff])
      else $error("walk reached an unmarked slot");

   // a finished walk leaves the expected slot unmarked
   a_idle_exp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rcvd_ff[exp_ff])
      else $error("expected slot marked while idle");

   // a pending report that is not the last one implies more walk to come
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_report) |-> (state_ff != ST_IDLE))
      else $error("non-final report with no walk pending");

   // an ack report is always loaded in the same cycle that a walk starts
   a_walk_after_ack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_WALK_RD) |=>
         (rsp_valid_ff && rsp_ff.report_kind == srr_pkg::KIND_ACK))
      else $error("walk started without an ack");
endmodule
